@@ rtl/fem_pkg.sv @@
// package for the flow exact match table
// holds key types, op and status codes, sizing constants
`default_nettype none
package fem_pkg;
  localparam int unsigned BucketsDef = 128;
  localparam int unsigned WaysDef = 4;
  localparam int unsigned KeyW = 64 * 4 + 32 + 36;
  localparam int unsigned HandleW = 16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_EXEC  = 2'd2,
    BK_OUT   = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tclass;
    logic [19:0] flow_tag;
    logic [15:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle_out;
  } rsp_t;

  function automatic logic [KeyW-1:0] key_of(req_t r);
    return {r.src_addr_hi, r.src_addr_lo, r.dst_addr_hi, r.dst_addr_lo,
            r.src_port, r.dst_port, r.protocol, r.tclass, r.flow_tag};
  endfunction

  function automatic logic [7:0] hash_of(logic [63:0] dst_hi);
    return dst_hi[63:56] ^ dst_hi[55:48] ^ dst_hi[47:40] ^ dst_hi[39:32];
  endfunction
endpackage
`default_nettype wire

@@ rtl/fem_if.sv @@
// handshake channel interfaces for the flow exact match table
// depends on fem_pkg
`default_nettype none
interface fem_req_if;
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  fem_pkg::req_t    req;
  modport source (output valid, output op, output req, input ready);
  modport sink (input valid, input op, input req, output ready);
endinterface

interface fem_rsp_if;
  logic          valid;
  logic          ready;
  fem_pkg::rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface
`default_nettype wire

@@ rtl/fem_ram.sv @@
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`default_nettype none
module fem_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [Width-1:0]  wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [Width-1:0]  rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/fem_front.sv @@
// front end: accepts requests, computes the bucket, two entry queue
// depends on fem_pkg
`default_nettype none
module fem_front #(
  parameter int unsigned Buckets = fem_pkg::BucketsDef,
  localparam int unsigned BW = (Buckets > 1) ? $clog2(Buckets) : 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     in_op_i,
  input  wire fem_pkg::req_t  in_req_i,
  output logic                q_valid_o,
  input  wire logic           q_pop_i,
  output logic [1:0]          q_op_o,
  output fem_pkg::req_t       q_req_o,
  output logic [BW-1:0]       q_bucket_o
);
  logic [1:0]          op_q [2];
  fem_pkg::req_t       req_q [2];
  logic [BW-1:0]       bkt_q [2];
  logic                wp_q, rp_q;
  logic [1:0]          cnt_q;
  logic [BW-1:0]       bkt_d;
  logic                push;
  logic [7:0]          hash;
  logic [BW-1:0]       mod_tbl [256];

  // hash modulo bucket count as a constant table
  assign hash = fem_pkg::hash_of(in_req_i.dst_addr_hi);
  for (genvar v = 0; v < 256; v++) begin : g_mod
    assign mod_tbl[v] = BW'(v % Buckets);
  end
  assign bkt_d = mod_tbl[hash];

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_op_o = op_q[rp_q];
  assign q_req_o = req_q[rp_q];
  assign q_bucket_o = bkt_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wp_q]  <= in_op_i;
      req_q[wp_q] <= in_req_i;
      bkt_q[wp_q] <= bkt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

@@ rtl/fem_back.sv @@
// back end: reads a bucket, compares all ways, writes back, answers
// depends on fem_pkg and fem_ram
`default_nettype none
module fem_back #(
  parameter int unsigned Buckets = fem_pkg::BucketsDef,
  parameter int unsigned Ways = fem_pkg::WaysDef,
  localparam int unsigned BW = (Buckets > 1) ? $clog2(Buckets) : 1,
  localparam int unsigned WW = (Ways > 1) ? $clog2(Ways) : 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  output logic                q_pop_o,
  input  wire logic [1:0]     q_op_i,
  input  wire fem_pkg::req_t  q_req_i,
  input  wire logic [BW-1:0]  q_bucket_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output fem_pkg::rsp_t       out_rsp_o
);
  localparam int unsigned EW = fem_pkg::KeyW + fem_pkg::HandleW;

  fem_pkg::back_state_e state_q, state_d;
  logic [Ways-1:0]   vrow;
  logic [Ways-1:0]   vwdata;
  logic              vwe;
  logic [BW-1:0]     vwaddr;
  logic              clr_busy_q;
  logic [BW-1:0]     clr_addr_q;
  logic [EW-1:0]     rdata [Ways];
  logic [Ways-1:0]   we;
  logic [Ways-1:0]   match;
  logic              found, has_free;
  logic [WW-1:0]     hit_w, free_w;
  fem_pkg::rsp_t     rsp_q, rsp_d;
  logic [fem_pkg::KeyW-1:0] key;

  assign key = fem_pkg::key_of(q_req_i);

  // valid bits of each bucket, cleared by a pass after reset
  assign vwaddr = clr_busy_q ? clr_addr_q : q_bucket_i;
  fem_ram #(.Width(Ways), .Depth(Buckets)) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (vwdata),
    .raddr_i (q_bucket_i),
    .rdata_o (vrow)
  );

  for (genvar w = 0; w < Ways; w++) begin : g_way
    fem_ram #(.Width(EW), .Depth(Buckets)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[w]),
      .waddr_i (q_bucket_i),
      .wdata_i ({key, q_req_i.handle_in}),
      .raddr_i (q_bucket_i),
      .rdata_o (rdata[w])
    );
    assign match[w] = vrow[w] && (rdata[w][EW-1:fem_pkg::HandleW] == key);
  end

  always_comb begin
    found = 1'b0;
    has_free = 1'b0;
    hit_w = '0;
    free_w = '0;
    for (int i = Ways - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        hit_w = WW'(i);
      end
      if (!vrow[i]) begin
        has_free = 1'b1;
        free_w = WW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fem_pkg::BK_IDLE: if (q_valid_i && !clr_busy_q) state_d = fem_pkg::BK_READ;
      fem_pkg::BK_READ: state_d = fem_pkg::BK_EXEC;
      fem_pkg::BK_EXEC: state_d = fem_pkg::BK_OUT;
      fem_pkg::BK_OUT:  if (out_ready_i) state_d = fem_pkg::BK_IDLE;
      default:          state_d = fem_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    we = '0;
    vwe = clr_busy_q;
    vwdata = '0;
    rsp_d = rsp_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      fem_pkg::BK_EXEC: begin
        q_pop_o = 1'b1;
        rsp_d = '{status: fem_pkg::ST_NOT_FOUND, handle_out: '0};
        case (q_op_i)
          fem_pkg::OP_LOOKUP: if (found) begin
            rsp_d.status = fem_pkg::ST_OK;
            rsp_d.handle_out = rdata[hit_w][fem_pkg::HandleW-1:0];
          end
          fem_pkg::OP_INSERT: begin
            if (found) rsp_d.status = fem_pkg::ST_EXISTS;
            else if (!has_free) rsp_d.status = fem_pkg::ST_FULL;
            else begin
              rsp_d.status = fem_pkg::ST_OK;
              we[free_w] = 1'b1;
              vwe = 1'b1;
              vwdata = vrow | (Ways'(1) << free_w);
            end
          end
          fem_pkg::OP_DELETE: if (found) begin
            rsp_d.status = fem_pkg::ST_OK;
            vwe = 1'b1;
            vwdata = vrow & ~(Ways'(1) << hit_w);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fem_pkg::BK_IDLE;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        if (clr_addr_q == BW'(Buckets - 1)) clr_busy_q <= 1'b0;
        else clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  assign out_valid_o = (state_q == fem_pkg::BK_OUT);
  assign out_rsp_o = rsp_q;
endmodule
`default_nettype wire

@@ rtl/flow_exact_match_table.sv @@
// top level of the flow exact match table
// depends on fem_pkg, fem_if, fem_front, fem_back, fem_ram
// The table holds Buckets x Ways flow entries keyed on the full IPv6 5-tuple plus
// traffic class and flow label. Each request is one lookup, insert or delete and gives
// exactly one response. The front end queues up to two requests; the back end handles
// one at a time, stepping through bucket read, then compare and write-back, then the
// response is held until taken, and it takes no new request before that response is
// taken. After reset the back end clears the valid bits of every bucket before it
// serves the first request; requests arriving meanwhile wait in the front queue.
`default_nettype none
module flow_exact_match_table #(
  parameter int unsigned Buckets = fem_pkg::BucketsDef,
  parameter int unsigned Ways = fem_pkg::WaysDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  fem_req_if.sink  req,
  fem_rsp_if.source rsp
);
  localparam int unsigned BW = (Buckets > 1) ? $clog2(Buckets) : 1;
  logic             q_valid, q_pop;
  logic [1:0]       q_op;
  fem_pkg::req_t    q_req;
  logic [BW-1:0]    q_bucket;

  fem_front #(.Buckets(Buckets)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid), .in_ready_o (req.ready),
    .in_op_i (req.op), .in_req_i (req.req),
    .q_valid_o (q_valid), .q_pop_i (q_pop),
    .q_op_o (q_op), .q_req_o (q_req), .q_bucket_o (q_bucket)
  );

  fem_back #(.Buckets(Buckets), .Ways(Ways)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid), .q_pop_o (q_pop),
    .q_op_i (q_op), .q_req_i (q_req), .q_bucket_i (q_bucket),
    .out_valid_o (rsp.valid), .out_ready_i (rsp.ready), .out_rsp_o (rsp.rsp)
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.rsp))
    else $error("response dropped");
  a_pop_then_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> rsp.valid) else $error("no response after pop");
endmodule
`default_nettype wire
